// ----- hdl/tpie_pkg.sv -----
// Shared types, codes and sizes for the two-pass instruction encoder.
`timescale 1ns / 1ps

package tpie_pkg;

  // Label table depth
  localparam int unsigned MAX_LABELS = 1024;

  // Widths fixed by the item formats
  localparam int unsigned KeyW  = 48;
  localparam int unsigned LineW = 16;
  localparam int unsigned WordW = 32;
  localparam int unsigned ErrW  = 3;

  // Mnemonic codes
  localparam logic [3:0] MN_ADD  = 4'd0;
  localparam logic [3:0] MN_NOR  = 4'd1;
  localparam logic [3:0] MN_LW   = 4'd2;
  localparam logic [3:0] MN_SW   = 4'd3;
  localparam logic [3:0] MN_BEQ  = 4'd4;
  localparam logic [3:0] MN_JALR = 4'd5;
  localparam logic [3:0] MN_HALT = 4'd6;
  localparam logic [3:0] MN_NOOP = 4'd7;
  localparam logic [3:0] MN_FILL = 4'd8;

  // Error codes
  localparam logic [ErrW-1:0] ERR_OK      = 3'd0;
  localparam logic [ErrW-1:0] ERR_DUP     = 3'd1;
  localparam logic [ErrW-1:0] ERR_UNDEF   = 3'd2;
  localparam logic [ErrW-1:0] ERR_REG     = 3'd3;
  localparam logic [ErrW-1:0] ERR_OFFSET  = 3'd4;
  localparam logic [ErrW-1:0] ERR_UNKNOWN = 3'd5;
  localparam logic [ErrW-1:0] ERR_NONNUM  = 3'd6;
  localparam logic [ErrW-1:0] ERR_STOP    = 3'd7;

  // One tokenized source line
  typedef struct packed {
    logic               pass_number;
    logic               has_label;
    logic [KeyW-1:0]    label_key;
    logic [3:0]         mnemonic;
    logic signed [31:0] reg_a;
    logic signed [31:0] reg_b;
    logic               regs_numeric;
    logic               operand_is_label;
    logic signed [31:0] operand_value;
    logic [KeyW-1:0]    operand_label;
  } item_t;

  // One encoder answer
  typedef struct packed {
    logic [WordW-1:0] machine_word;
    logic             word_valid;
    logic [ErrW-1:0]  error_code;
  } result_t;

  // Status from the label search unit
  typedef struct packed {
    logic             done;
    logic             hit;
    logic [LineW-1:0] line;
  } srch_res_t;

endpackage

// ----- hdl/tpie_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module tpie_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 1024
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ----- hdl/tpie_search.sv -----
// Label search: one shared key comparator walks the table one entry a cycle.
`timescale 1ns / 1ps

module tpie_search #(
  parameter int unsigned MaxLabels = tpie_pkg::MAX_LABELS,
  localparam int unsigned AddrW = (MaxLabels > 1) ? $clog2(MaxLabels) : 1,
  localparam int unsigned CntW  = $clog2(MaxLabels + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       go_i,
  input  logic [tpie_pkg::KeyW-1:0]  key_i,
  input  logic [CntW-1:0]            count_i,
  output logic                       rd_en_o,
  output logic [AddrW-1:0]           rd_addr_o,
  input  logic [tpie_pkg::KeyW-1:0]  rd_key_i,
  input  logic [tpie_pkg::LineW-1:0] rd_line_i,
  output tpie_pkg::srch_res_t        res_o
);

  logic                       active_q;
  logic                       pend_q;
  logic [CntW-1:0]            idx_q;
  logic                       done_q;
  logic                       hit_q;
  logic [tpie_pkg::LineW-1:0] line_q;
  logic                       issue;
  logic                       match;
  logic                       resolve;

  // Issue a read while entries remain, compare the entry read last cycle
  assign issue     = active_q && (idx_q < count_i);
  assign match     = active_q && pend_q && (rd_key_i == key_i);
  assign resolve   = match || (active_q && !issue && !pend_q);
  assign rd_en_o   = issue;
  assign rd_addr_o = idx_q[AddrW-1:0];

  // Advance the scan, drop out on a hit or at the end of the table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      pend_q   <= 1'b0;
      idx_q    <= '0;
      done_q   <= 1'b0;
      hit_q    <= 1'b0;
    end else if (go_i) begin
      active_q <= 1'b1;
      pend_q   <= 1'b0;
      idx_q    <= '0;
      done_q   <= 1'b0;
      hit_q    <= 1'b0;
    end else begin
      done_q <= resolve;
      if (active_q) begin
        idx_q  <= idx_q + CntW'(issue);
        pend_q <= issue;
        if (resolve) begin
          active_q <= 1'b0;
          hit_q    <= match;
        end
      end
    end
  end

  // Hold the line number of the matching entry
  always_ff @(posedge clk_i) begin
    if (match) begin
      line_q <= rd_line_i;
    end
  end

  assign res_o.done = done_q;
  assign res_o.hit  = hit_q;
  assign res_o.line = line_q;

endmodule

// ----- hdl/tpie_encode.sv -----
// Second-pass checks and packing of one line into a machine word.
`timescale 1ns / 1ps

module tpie_encode (
  input  tpie_pkg::item_t              item_i,
  input  logic                         found_i,
  input  logic [tpie_pkg::LineW-1:0]   label_line_i,
  input  logic [tpie_pkg::LineW-1:0]   line_cnt_i,
  output logic [tpie_pkg::ErrW-1:0]    err_o,
  output logic [tpie_pkg::WordW-1:0]   word_o
);

  logic               ra_ok;
  logic               rb_ok;
  logic               val_ok;
  logic               off_ok;
  logic [2:0]         op3;
  logic [16:0]        next_line;
  logic signed [17:0] beq_off;
  logic signed [31:0] off;

  // Register numbers 0..7 have no bits above bit 2
  assign ra_ok  = (item_i.reg_a[31:3] == '0);
  assign rb_ok  = (item_i.reg_b[31:3] == '0);
  assign val_ok = (item_i.operand_value[31:3] == '0);
  assign op3    = item_i.mnemonic[2:0];

  // Resolve the offset: PC-relative for beq, absolute for lw/sw
  assign next_line = {1'b0, line_cnt_i} + 17'd1;
  assign beq_off   = $signed({2'b00, label_line_i}) - $signed({1'b0, next_line});
  always_comb begin
    if (!item_i.operand_is_label) begin
      off = item_i.operand_value;
    end else if (item_i.mnemonic == tpie_pkg::MN_BEQ) begin
      off = 32'(beq_off);
    end else begin
      off = {16'd0, label_line_i};
    end
  end

  // 16-bit signed range: upper 17 bits all equal
  assign off_ok = (off[31:15] == '0) || (off[31:15] == '1);

  // Check and pack
  always_comb begin
    err_o  = tpie_pkg::ERR_OK;
    word_o = '0;
    unique case (item_i.mnemonic)
      tpie_pkg::MN_ADD, tpie_pkg::MN_NOR: begin
        if (!item_i.regs_numeric || item_i.operand_is_label) begin
          err_o = tpie_pkg::ERR_NONNUM;
        end else if (!ra_ok || !rb_ok || !val_ok) begin
          err_o = tpie_pkg::ERR_REG;
        end else begin
          word_o = {7'd0, op3, item_i.reg_a[2:0], item_i.reg_b[2:0], 13'd0,
                    item_i.operand_value[2:0]};
        end
      end
      tpie_pkg::MN_LW, tpie_pkg::MN_SW, tpie_pkg::MN_BEQ: begin
        if (!item_i.regs_numeric) begin
          err_o = tpie_pkg::ERR_NONNUM;
        end else if (item_i.operand_is_label && !found_i) begin
          err_o = tpie_pkg::ERR_UNDEF;
        end else if (!ra_ok || !rb_ok) begin
          err_o = tpie_pkg::ERR_REG;
        end else if (!off_ok) begin
          err_o = tpie_pkg::ERR_OFFSET;
        end else begin
          word_o = {7'd0, op3, item_i.reg_a[2:0], item_i.reg_b[2:0], off[15:0]};
        end
      end
      tpie_pkg::MN_JALR: begin
        if (!item_i.regs_numeric) begin
          err_o = tpie_pkg::ERR_NONNUM;
        end else if (!ra_ok || !rb_ok) begin
          err_o = tpie_pkg::ERR_REG;
        end else begin
          word_o = {7'd0, op3, item_i.reg_a[2:0], item_i.reg_b[2:0], 16'd0};
        end
      end
      tpie_pkg::MN_HALT, tpie_pkg::MN_NOOP: begin
        word_o = {7'd0, op3, 22'd0};
      end
      tpie_pkg::MN_FILL: begin
        if (item_i.operand_is_label) begin
          if (!found_i) begin
            err_o = tpie_pkg::ERR_UNDEF;
          end else begin
            word_o = {16'd0, label_line_i};
          end
        end else begin
          word_o = item_i.operand_value;
        end
      end
      default: begin
        err_o = tpie_pkg::ERR_UNKNOWN;
      end
    endcase
  end

endmodule

// ----- hdl/two_pass_instruction_encoder.sv -----
// Top level of the two-pass instruction encoder: sequencer, label table, result register.
`timescale 1ns / 1ps

// Each item is one tokenized source line. Raise start_i while busy_o is low; the
// answer appears on result_o for exactly one cycle with done_o high and cannot be
// held off. A line that needs no label lookup goes from idle straight to the
// finish state, where its answer is registered. A line that defines a label in
// the first pass, or resolves a label operand in the second, searches the label
// table one entry per cycle through a single comparator and a single memory
// read port. busy_o stays high for the whole item. The label table needs no
// clearing after reset, so the block takes items right away. After the first
// error every further item answers error 7 until reset.
module two_pass_instruction_encoder #(
  parameter int unsigned MaxLabels = tpie_pkg::MAX_LABELS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  tpie_pkg::item_t   item_i,
  output logic              done_o,
  output tpie_pkg::result_t result_o
);

  localparam int unsigned AddrW = (MaxLabels > 1) ? $clog2(MaxLabels) : 1;
  localparam int unsigned CntW  = $clog2(MaxLabels + 1);
  localparam int unsigned EntW  = tpie_pkg::KeyW + tpie_pkg::LineW;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_FINISH = 3'b100
  } state_e;

  state_e                      state_q, state_d;
  tpie_pkg::item_t             item_q;
  logic                        srch_q;
  logic [CntW-1:0]             count_q;
  logic [tpie_pkg::LineW-1:0]  line_q;
  logic                        pass_q;
  logic                        stopped_q;
  logic                        done_q;
  tpie_pkg::result_t           result_q;

  logic                        accept;
  logic                        need_search;
  logic                        is_mem_op;
  logic                        finish;
  logic                        found;
  logic                        full;
  logic                        tbl_we;
  tpie_pkg::result_t           res_d;
  logic [tpie_pkg::ErrW-1:0]   enc_err;
  logic [tpie_pkg::WordW-1:0]  enc_word;
  logic [tpie_pkg::KeyW-1:0]   srch_key;
  logic                        rd_en;
  logic [AddrW-1:0]            rd_addr;
  logic [EntW-1:0]             rd_data;
  tpie_pkg::srch_res_t         srch_res;

  assign accept = start_i && (state_q == ST_IDLE);
  assign busy_o = (state_q != ST_IDLE);
  assign finish = (state_q == ST_FINISH);

  // Decide at accept whether the line needs a table walk
  assign is_mem_op = (item_i.mnemonic == tpie_pkg::MN_LW) ||
                     (item_i.mnemonic == tpie_pkg::MN_SW) ||
                     (item_i.mnemonic == tpie_pkg::MN_BEQ);
  always_comb begin
    if (stopped_q) begin
      need_search = 1'b0;
    end else if (!item_i.pass_number) begin
      need_search = item_i.has_label;
    end else begin
      need_search = item_i.operand_is_label &&
                    ((is_mem_op && item_i.regs_numeric) ||
                     (item_i.mnemonic == tpie_pkg::MN_FILL));
    end
  end

  // Sequence one item
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = need_search ? ST_SEARCH : ST_FINISH;
        end
      end
      ST_SEARCH: begin
        if (srch_res.done) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Label table: key in the upper bits, line number in the lower
  assign srch_key = item_q.pass_number ? item_q.operand_label : item_q.label_key;

  tpie_search #(
    .MaxLabels (MaxLabels)
  ) u_search (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .go_i      (accept && need_search),
    .key_i     (srch_key),
    .count_i   (count_q),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr),
    .rd_key_i  (rd_data[EntW-1:tpie_pkg::LineW]),
    .rd_line_i (rd_data[tpie_pkg::LineW-1:0]),
    .res_o     (srch_res)
  );

  tpie_ram #(
    .Width (EntW),
    .Depth (MaxLabels)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (count_q[AddrW-1:0]),
    .wdata_i ({item_q.label_key, line_q}),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // Second-pass encoding
  assign found = srch_q && srch_res.hit;

  tpie_encode u_encode (
    .item_i       (item_q),
    .found_i      (found),
    .label_line_i (srch_res.line),
    .line_cnt_i   (line_q),
    .err_o        (enc_err),
    .word_o       (enc_word)
  );

  // Form the answer in the finish cycle
  assign full   = (count_q == CntW'(MaxLabels));
  assign tbl_we = finish && !stopped_q && !item_q.pass_number && item_q.has_label &&
                  !found && !full;
  always_comb begin
    res_d.machine_word = '0;
    res_d.word_valid   = 1'b0;
    res_d.error_code   = tpie_pkg::ERR_OK;
    if (stopped_q) begin
      res_d.error_code = tpie_pkg::ERR_STOP;
    end else if (!item_q.pass_number) begin
      if (item_q.has_label && found) begin
        res_d.error_code = tpie_pkg::ERR_DUP;
      end else if (item_q.has_label && full) begin
        res_d.error_code = tpie_pkg::ERR_STOP;
      end
    end else begin
      res_d.error_code = enc_err;
      if (enc_err == tpie_pkg::ERR_OK) begin
        res_d.word_valid   = 1'b1;
        res_d.machine_word = enc_word;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      line_q    <= '0;
      pass_q    <= 1'b0;
      stopped_q <= 1'b0;
      done_q    <= 1'b0;
      srch_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= finish;
      if (accept) begin
        srch_q <= need_search;
        // Restart the line counter on a change of pass
        if (!stopped_q && (item_i.pass_number != pass_q)) begin
          pass_q <= item_i.pass_number;
          line_q <= '0;
        end
      end
      if (finish && !stopped_q) begin
        if (res_d.error_code != tpie_pkg::ERR_OK) begin
          stopped_q <= 1'b1;
        end else begin
          line_q <= line_q + tpie_pkg::LineW'(1);
        end
        if (tbl_we) begin
          count_q <= count_q + CntW'(1);
        end
      end
    end
  end

  // Item and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
    if (finish) begin
      result_q <= res_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;

  // Result strobe lasts one cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  // A valid word always carries no error
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.word_valid) |-> (result_o.error_code == tpie_pkg::ERR_OK))
    else $error("valid word with error code");

  // Once stopped, the block stays stopped
  assert property (@(posedge clk_i) disable iff (!rst_ni) stopped_q |=> stopped_q)
    else $error("stop flag cleared");

  // Label count never passes the table depth
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CntW'(MaxLabels))
    else $error("label count overflow");

  // A stopped block answers error 7
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (finish && stopped_q) |=> (done_o && (result_o.error_code == tpie_pkg::ERR_STOP)))
    else $error("stopped block gave a different answer");

endmodule
